[hw/rtl/fnvbi_pkg.sv]
// shared types and constants for the fnv-1a bucket index block
// no dependencies; imported by fnvbi_div and the top level
`default_nettype none

package fnvbi_pkg;

    // hash and bucket width
    localparam int HASH_W = 32;
    // divider step counter width
    localparam int STEP_W = $clog2(HASH_W);

    // fnv-1a offset basis and prime
    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    // bucket count after reset
    localparam logic [HASH_W-1:0] BUCKET_COUNT_RESET = 32'd11;

    // register index of bucket_count
    localparam logic [1:0] REG_BUCKET_COUNT = 2'd0;

    // request to the divider
    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [HASH_W-1:0] divisor;
    } div_req_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/fnvbi_div.sv]
// restoring remainder unit, one quotient bit per cycle
// depends on fnvbi_pkg
`default_nettype none

module fnvbi_div
    import fnvbi_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire div_req_t          req,
    output div_rsp_t               rsp,
    output logic [HASH_W-1:0]      remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [HASH_W-1:0] rem_reg, rem_next;
    logic [HASH_W-1:0] shift_reg, shift_next;
    logic [HASH_W-1:0] divisor_reg, divisor_next;

    logic [HASH_W:0]   shifted;
    logic [HASH_W:0]   trial;

    // one compare-and-subtract step
    always_comb begin
        shifted = {rem_reg, shift_reg[HASH_W-1]};
        trial   = shifted - {1'b0, divisor_reg};
    end

    // sequencer
    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        if (req.start) begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = '0;
            shift_next   = req.dividend;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            shift_next = {shift_reg[HASH_W-2:0], 1'b0};
            if (!trial[HASH_W]) begin
                rem_next = trial[HASH_W-1:0];
            end else begin
                rem_next = shifted[HASH_W-1:0];
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(HASH_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[hw/rtl/fnv1a_string_bucket_index_core.sv]
// top level of the fnv-1a string hash and bucket index block
// depends on fnvbi_pkg and fnvbi_div
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  s_      | in        | s_tvalid/s_tready  | tdata[7:0] key_byte, tuser has_byte,
//          |           |                    | tlast last_byte
//  m_      | out       | m_tvalid/m_tready  | tdata[31:0] hash_value,
//          |           |                    | tdata[63:32] bucket_index
//  apb     | in        | psel/penable       | reg 0 bucket_count at address 0
//
// a byte item that is not last does not stop input: the hash multiply is a constant
// multiply in the accept cycle. a last item holds s_tready low while the remainder
// unit, loaded on the accept edge, runs its 32 steps, the sequencer sees done, and
// the result is handed off once the output register is free. a finished result
// waits in an output register and does not stop input unless a second last item
// finishes first. reset restores the offset basis and bucket_count 11; no
// clearing pass.
`default_nettype none

module fnv1a_string_bucket_index_core
    import fnvbi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
    input  wire logic        s_tuser,   // [0] has_byte
    input  wire logic        s_tlast,   // last_byte
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] hash_value, [63:32] bucket_index
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [HASH_W-1:0] running_reg, running_next;
    logic [HASH_W-1:0] bucket_count_reg;
    logic [HASH_W-1:0] key_hash_reg, key_hash_next;
    logic              zero_div_reg, zero_div_next;
    logic              out_valid_reg, out_valid_next;
    logic [HASH_W-1:0] out_hash_reg, out_hash_next;
    logic [HASH_W-1:0] out_bucket_reg, out_bucket_next;

    logic              s_accept;
    logic              m_accept;
    logic              out_free;
    logic [HASH_W-1:0] mixed;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic [HASH_W-1:0] div_rem;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_BUCKET_COUNT) ? bucket_count_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= BUCKET_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_BUCKET_COUNT) begin
            bucket_count_reg <= pwdata;
        end
    end

    // handshakes
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = out_valid_reg && m_tready;
    assign out_free = !out_valid_reg || m_tready;

    // hash update for one byte
    always_comb begin
        mixed = running_reg;
        if (s_tuser) begin
            mixed = (running_reg ^ {{(HASH_W-8){1'b0}}, s_tdata}) * FNV_PRIME;
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        running_next    = running_reg;
        key_hash_next   = key_hash_reg;
        zero_div_next   = zero_div_reg;
        out_valid_next  = out_valid_reg;
        out_hash_next   = out_hash_reg;
        out_bucket_next = out_bucket_reg;
        div_req.start    = 1'b0;
        div_req.dividend = mixed;
        div_req.divisor  = bucket_count_reg;

        if (m_accept) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tlast) begin
                        running_next  = FNV_BASIS;
                        key_hash_next = mixed;
                        zero_div_next = (bucket_count_reg == '0);
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        running_next = mixed;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_hash_next   = key_hash_reg;
                    out_bucket_next = zero_div_reg ? '0 : div_rem;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            running_reg   <= FNV_BASIS;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_hash_reg   <= key_hash_next;
        zero_div_reg   <= zero_div_next;
        out_hash_reg   <= out_hash_next;
        out_bucket_reg <= out_bucket_next;
    end

    // single remainder unit
    fnvbi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .rsp       (div_rsp),
        .remainder (div_rem)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bucket_reg, out_hash_reg};

endmodule

`default_nettype wire
